[hw/rtl/scc_pkg.sv]
package scc_pkg;

    // Field widths fixed by the interface
    localparam int VERTEX_W   = 7;
    localparam int COUNT_W    = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register map: word index is paddr[2]
    localparam logic REG_IDX_VERTEX_COUNT = 1'b0;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    typedef enum logic [2:0] {
        TOP_CLEAR,
        TOP_IDLE,
        TOP_EDGE2,
        TOP_FWD,
        TOP_REV,
        TOP_RESULT
    } t_top_state;

    typedef enum logic [2:0] {
        SRCH_IDLE,
        SRCH_INIT,
        SRCH_POP,
        SRCH_NODE,
        SRCH_ROW,
        SRCH_SCAN,
        SRCH_DONE
    } t_srch_state;

    typedef struct packed {
        logic done;
        logic all_reached;
    } t_srch_status;

endpackage

[hw/rtl/scc_ram.sv]
module scc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [WIDTH-1:0]         i_wr_mask,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Bit-masked write: only bits with mask set change
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int i = 0; i < WIDTH; i++) begin
                if (i_wr_mask[i]) begin
                    r_mem[i_wr_addr][i] <= i_wr_data[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/scc_search.sv]
module scc_search
    import scc_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]   i_count,
    input  logic [MAX_VERTICES-1:0]             i_mask,
    output logic                                o_row_rd_en,
    output logic [$clog2(MAX_VERTICES)-1:0]     o_row_addr,
    input  logic [MAX_VERTICES-1:0]             i_row_data,
    output t_srch_status                        o_status
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    t_srch_state             r_state, n_state;
    logic [CW-1:0]           r_head, n_head;
    logic [CW-1:0]           r_tail, n_tail;
    logic [CW-1:0]           r_idx, n_idx;
    logic [MAX_VERTICES-1:0] r_reached, n_reached;
    logic [MAX_VERTICES-1:0] r_row, n_row;

    logic                    w_q_we;
    logic [AW-1:0]           w_q_waddr;
    logic [AW-1:0]           w_q_wdata;
    logic                    w_q_re;
    logic [AW-1:0]           w_q_rdata;
    logic                    w_hit;

    // Queue of vertices still to expand
    scc_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_VERTICES)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (w_q_we),
        .i_wr_addr (w_q_waddr),
        .i_wr_data (w_q_wdata),
        .i_wr_mask ({AW{1'b1}}),
        .i_rd_en   (w_q_re),
        .i_rd_addr (r_head[AW-1:0]),
        .o_rd_data (w_q_rdata)
    );

    assign w_hit = r_row[0] && !r_reached[r_idx[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SRCH_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_reached <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_reached <= n_reached;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_row <= n_row;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_idx       = r_idx;
        n_reached   = r_reached;
        n_row       = r_row;
        w_q_we      = 1'b0;
        w_q_waddr   = r_tail[AW-1:0];
        w_q_wdata   = r_idx[AW-1:0];
        w_q_re      = 1'b0;
        o_row_rd_en = 1'b0;
        o_row_addr  = w_q_rdata;
        o_status    = '{done: 1'b0, all_reached: 1'b0};

        unique case (r_state)
            SRCH_IDLE: begin
                if (i_start) begin
                    n_state = SRCH_INIT;
                end
            end
            SRCH_INIT: begin
                // Seed the queue with vertex one
                w_q_we    = 1'b1;
                w_q_waddr = '0;
                w_q_wdata = '0;
                n_reached = ROW_ONE;
                n_head    = '0;
                n_tail    = CW'(1);
                n_state   = SRCH_POP;
            end
            SRCH_POP: begin
                if (r_head == r_tail) begin
                    n_state = SRCH_DONE;
                end else begin
                    w_q_re  = 1'b1;
                    n_head  = r_head + CW'(1);
                    n_state = SRCH_NODE;
                end
            end
            SRCH_NODE: begin
                o_row_rd_en = 1'b1;
                n_state     = SRCH_ROW;
            end
            SRCH_ROW: begin
                n_row   = i_row_data;
                n_idx   = '0;
                n_state = SRCH_SCAN;
            end
            SRCH_SCAN: begin
                // One neighbor bit per cycle: mark and enqueue new vertices
                if (w_hit) begin
                    w_q_we    = 1'b1;
                    n_reached = r_reached | (ROW_ONE << r_idx[AW-1:0]);
                    n_tail    = r_tail + CW'(1);
                end
                n_row = r_row >> 1;
                n_idx = r_idx + CW'(1);
                if (r_idx == i_count - CW'(1)) begin
                    n_state = SRCH_POP;
                end
            end
            SRCH_DONE: begin
                o_status = '{done: 1'b1, all_reached: &(r_reached | ~i_mask)};
                n_state  = i_start ? SRCH_INIT : SRCH_IDLE;
            end
            default: begin
                n_state = SRCH_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_head_behind_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_queue_matches_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SRCH_POP) |-> ($countones(r_reached) == int'(r_tail)))
        else $error("enqueued count differs from reached set");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SRCH_SCAN) |-> (r_idx < i_count))
        else $error("scan index beyond vertex count");
`endif

endmodule

[hw/rtl/strong_connectivity_check_top.sv]
// Strong connectivity check. Load a graph one edge per input transaction
// (from_vertex, to_vertex, two_way, last_edge); vertices are numbered from
// one and an edge naming vertex 0 or a vertex above the effective count
// is dropped. vertex_count (APB register at byte address 0, reset 64)
// acts as 1 when written 0 and as MAX_VERTICES above that; write it only
// while the block is idle. A two-way edge writes its reverse direction in
// a separate state, with input stall high. The transaction that carries
// last_edge starts a breadth-first search from vertex one over the forward
// adjacency store and, if that reaches every vertex, a second one over the
// reverse store. The search unit reads one queue entry and one adjacency
// row per vertex and then walks that row one bit per cycle. The single
// result bit lands in an output register, so it can wait for the consumer
// while the block goes on. Both stores are then swept to zero, one row a
// cycle; the same sweep runs after reset. Input stall stays high during
// searches and sweeps.
module strong_connectivity_check_top
    import scc_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // edge input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VERTEX_W-1:0]   i_from_vertex,
    input  logic [VERTEX_W-1:0]   i_to_vertex,
    input  logic                  i_two_way,
    input  logic                  i_last_edge,
    // result output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_strongly_connected
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    t_top_state             r_state, n_state;
    logic [COUNT_W-1:0]     r_vertex_count;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_bit, n_out_bit;
    logic                   r_ok, n_ok;
    logic [AW-1:0]          r_edge_a, n_edge_a;
    logic [AW-1:0]          r_edge_b, n_edge_b;
    logic                   r_last, n_last;

    logic [CW-1:0]           w_count;
    logic [MAX_VERTICES-1:0] w_mask;
    logic                    w_cfg_wr;
    logic                    w_in_accept;
    logic                    w_edge_ok;
    logic [VERTEX_W-1:0]     w_from_m1;
    logic [VERTEX_W-1:0]     w_to_m1;
    logic [AW+VERTEX_W-1:0]  w_from_ext;
    logic [AW+VERTEX_W-1:0]  w_to_ext;
    logic [AW-1:0]           w_edge_a;
    logic [AW-1:0]           w_edge_b;
    logic [AW-1:0]           w_src;
    logic [AW-1:0]           w_dst;

    logic                    w_fwd_we, w_rev_we;
    logic [AW-1:0]           w_fwd_waddr, w_rev_waddr;
    logic [MAX_VERTICES-1:0] w_fwd_mask, w_rev_mask;
    logic [MAX_VERTICES-1:0] w_wdata;
    logic [MAX_VERTICES-1:0] w_fwd_rdata, w_rev_rdata, w_row_data;

    logic                    w_srch_start;
    logic                    w_srch_rd_en;
    logic [AW-1:0]           w_srch_addr;
    t_srch_status            w_srch_status;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                   && (paddr[2] == REG_IDX_VERTEX_COUNT);
    assign prdata   = (paddr[2] == REG_IDX_VERTEX_COUNT)
                    ? {{(APB_DATA_W-COUNT_W){1'b0}}, r_vertex_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VERTEX_COUNT_RESET;
        end else if (w_cfg_wr) begin
            r_vertex_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Effective vertex count: zero acts as one, clamp at the store size
    always_comb begin
        if (r_vertex_count == '0) begin
            w_count = CW'(1);
        end else if (32'(r_vertex_count) > 32'(MAX_VERTICES)) begin
            w_count = CW'(MAX_VERTICES);
        end else begin
            w_count = CW'(r_vertex_count);
        end
    end

    // Vertices that count toward the answer
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_mask
        assign w_mask[g] = 32'(g) < 32'(w_count);
    end

    // ---------------------------------------------------------------
    // Edge decode
    // ---------------------------------------------------------------
    assign w_in_accept = i_valid && !o_stall;
    assign w_edge_ok   = (i_from_vertex != '0) && (i_to_vertex != '0)
                      && (32'(i_from_vertex) <= 32'(w_count))
                      && (32'(i_to_vertex) <= 32'(w_count));
    assign w_from_m1   = i_from_vertex - VERTEX_W'(1);
    assign w_to_m1     = i_to_vertex - VERTEX_W'(1);
    assign w_from_ext  = {{AW{1'b0}}, w_from_m1};
    assign w_to_ext    = {{AW{1'b0}}, w_to_m1};
    assign w_edge_a    = w_from_ext[AW-1:0];
    assign w_edge_b    = w_to_ext[AW-1:0];

    // The EDGE2 state of a two-way edge swaps the roles of the two vertices
    assign w_src = (r_state == TOP_EDGE2) ? r_edge_b : w_edge_a;
    assign w_dst = (r_state == TOP_EDGE2) ? r_edge_a : w_edge_b;

    // ---------------------------------------------------------------
    // Adjacency stores: row = source vertex (forward) or target (reverse)
    // ---------------------------------------------------------------
    scc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_fwd_rows (
        .i_clk     (i_clk),
        .i_wr_en   (w_fwd_we),
        .i_wr_addr (w_fwd_waddr),
        .i_wr_data (w_wdata),
        .i_wr_mask (w_fwd_mask),
        .i_rd_en   (w_srch_rd_en && (r_state == TOP_FWD)),
        .i_rd_addr (w_srch_addr),
        .o_rd_data (w_fwd_rdata)
    );

    scc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_rev_rows (
        .i_clk     (i_clk),
        .i_wr_en   (w_rev_we),
        .i_wr_addr (w_rev_waddr),
        .i_wr_data (w_wdata),
        .i_wr_mask (w_rev_mask),
        .i_rd_en   (w_srch_rd_en && (r_state == TOP_REV)),
        .i_rd_addr (w_srch_addr),
        .o_rd_data (w_rev_rdata)
    );

    assign w_row_data = (r_state == TOP_REV) ? w_rev_rdata : w_fwd_rdata;

    // ---------------------------------------------------------------
    // Breadth-first search unit, shared by both passes
    // ---------------------------------------------------------------
    scc_search #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_srch_start),
        .i_count     (w_count),
        .i_mask      (w_mask),
        .o_row_rd_en (w_srch_rd_en),
        .o_row_addr  (w_srch_addr),
        .i_row_data  (w_row_data),
        .o_status    (w_srch_status)
    );

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TOP_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_bit <= n_out_bit;
        r_ok      <= n_ok;
        r_edge_a  <= n_edge_a;
        r_edge_b  <= n_edge_b;
        r_last    <= n_last;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        // drop the held result once the consumer takes it
        n_out_valid  = r_out_valid && i_stall;
        n_out_bit    = r_out_bit;
        n_ok         = r_ok;
        n_edge_a     = r_edge_a;
        n_edge_b     = r_edge_b;
        n_last       = r_last;
        w_srch_start = 1'b0;
        w_fwd_we     = 1'b0;
        w_rev_we     = 1'b0;
        w_fwd_waddr  = w_src;
        w_rev_waddr  = w_dst;
        w_fwd_mask   = ROW_ONE << w_dst;
        w_rev_mask   = ROW_ONE << w_src;
        w_wdata      = '1;

        unique case (r_state)
            TOP_CLEAR: begin
                // sweep one row of each store per cycle
                w_fwd_we    = 1'b1;
                w_rev_we    = 1'b1;
                w_fwd_waddr = r_clr_addr;
                w_rev_waddr = r_clr_addr;
                w_fwd_mask  = '1;
                w_rev_mask  = '1;
                w_wdata     = '0;
                n_clr_addr  = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_VERTICES - 1)) begin
                    n_state = TOP_IDLE;
                end
            end
            TOP_IDLE: begin
                if (w_in_accept) begin
                    n_edge_a = w_edge_a;
                    n_edge_b = w_edge_b;
                    n_last   = i_last_edge;
                    if (w_edge_ok) begin
                        w_fwd_we = 1'b1;
                        w_rev_we = 1'b1;
                    end
                    if (w_edge_ok && i_two_way) begin
                        n_state = TOP_EDGE2;
                    end else if (i_last_edge) begin
                        w_srch_start = 1'b1;
                        n_state      = TOP_FWD;
                    end
                end
            end
            TOP_EDGE2: begin
                w_fwd_we = 1'b1;
                w_rev_we = 1'b1;
                if (r_last) begin
                    w_srch_start = 1'b1;
                    n_state      = TOP_FWD;
                end else begin
                    n_state = TOP_IDLE;
                end
            end
            TOP_FWD: begin
                // skip the reverse pass once the forward pass has failed
                if (w_srch_status.done) begin
                    if (w_srch_status.all_reached) begin
                        w_srch_start = 1'b1;
                        n_state      = TOP_REV;
                    end else begin
                        n_ok    = 1'b0;
                        n_state = TOP_RESULT;
                    end
                end
            end
            TOP_REV: begin
                if (w_srch_status.done) begin
                    n_ok    = w_srch_status.all_reached;
                    n_state = TOP_RESULT;
                end
            end
            TOP_RESULT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_ok;
                    n_clr_addr  = '0;
                    n_state     = TOP_CLEAR;
                end
            end
            default: begin
                n_state = TOP_CLEAR;
            end
        endcase
    end

    assign o_stall              = (r_state != TOP_IDLE);
    assign o_valid              = r_out_valid;
    assign o_strongly_connected = r_out_bit;

`ifndef SYNTHESIS
    a_done_only_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_srch_status.done |-> (r_state == TOP_FWD || r_state == TOP_REV))
        else $error("search finished outside a search phase");

    a_no_store_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TOP_FWD || r_state == TOP_REV) |-> !(w_fwd_we || w_rev_we))
        else $error("adjacency store written during a search");

    a_result_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == TOP_RESULT))
        else $error("result raised without a finished check");

    a_sweep_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TOP_RESULT && !r_out_valid)
            |=> (r_state == TOP_CLEAR && r_clr_addr == '0))
        else $error("store sweep did not start from row zero after a result");
`endif

endmodule

[test/strong_connectivity_check_top_tb.sv]
`timescale 1ns / 100ps

module strong_connectivity_check_top_tb;
    import scc_pkg::*;

    localparam int MAX_V = 64;
    // Sweep of both stores (one row a cycle) plus a trailing two-way edge, with margin
    localparam int SETTLE_CYCLES = 2 * MAX_V + 8;
    localparam int END_CYCLES    = 4 * MAX_V;
    localparam int RANDOM_ITEMS  = 600;
    // Drop all idling and stalling once this many in-range random edges are queued
    localparam int CALM_AFTER    = 510;
    // About 70 graphs, mostly tiny. A 64-vertex graph costs two searches;
    // even if every graph were that large, the run would still end well below
    // this limit.
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam logic [APB_ADDR_W-1:0] VERTEX_COUNT_ADDR = {REG_IDX_VERTEX_COUNT, 2'b00};

    typedef struct packed {
        logic [VERTEX_W-1:0] from_v;
        logic [VERTEX_W-1:0] to_v;
        logic                two_way;
        logic                is_last;
    } arc_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [VERTEX_W-1:0]   i_from_vertex = '0;
    logic [VERTEX_W-1:0]   i_to_vertex = '0;
    logic                  i_two_way = 1'b0;
    logic                  i_last_edge = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_strongly_connected;

    strong_connectivity_check_top #(
        .MAX_VERTICES(MAX_V)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_from_vertex       (i_from_vertex),
        .i_to_vertex         (i_to_vertex),
        .i_two_way           (i_two_way),
        .i_last_edge         (i_last_edge),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_strongly_connected(o_strongly_connected)
    );

    // Shadow of the block: adjacency rows, vertex count, pending verdicts
    bit [MAX_V-1:0]      fwd_rows [MAX_V];
    bit [MAX_V-1:0]      rev_rows [MAX_V];
    bit [COUNT_W-1:0]    count_reg = VERTEX_COUNT_RESET;
    bit                  connected_exp_q [$];
    arc_t                arc_q [$];

    int unsigned         mismatches = 0;
    int unsigned         cycle_cnt = 0;
    int unsigned         random_live = 0;
    int unsigned         gap_left = 0;
    int unsigned         stall_left = 0;
    bit                  calm = 1'b0;
    bit                  want_connected;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int unsigned live_count(bit [COUNT_W-1:0] c);
        if (c < 1) return 1;
        if (c > MAX_V) return MAX_V;
        return c;
    endfunction

    // Reachability from vertex one, limited to the first n vertices
    function automatic bit reaches_all(bit use_rev, int unsigned n);
        bit [MAX_V-1:0] mask;
        bit [MAX_V-1:0] seen;
        bit [MAX_V-1:0] row;
        bit             grew;
        mask = (n >= MAX_V) ? '1 : ((64'd1 << n) - 64'd1);
        seen = 64'd1;
        do begin
            grew = 1'b0;
            for (int v = 0; v < n; v++) begin
                if (seen[v]) begin
                    row = use_rev ? rev_rows[v] : fwd_rows[v];
                    if ((row & mask & ~seen) != 0) begin
                        seen |= row & mask;
                        grew = 1'b1;
                    end
                end
            end
        end while (grew);
        return seen == mask;
    endfunction

    // Store one accepted edge; on the last one, queue the verdict and clear the graph
    function automatic void absorb_arc(bit [6:0] f, bit [6:0] t, bit two, bit last);
        int unsigned n;
        int unsigned a;
        int unsigned b;
        n = live_count(count_reg);
        if (f >= 1 && t >= 1 && f <= n && t <= n) begin
            a = f - 1;
            b = t - 1;
            fwd_rows[a][b] = 1'b1;
            rev_rows[b][a] = 1'b1;
            if (two) begin
                fwd_rows[b][a] = 1'b1;
                rev_rows[a][b] = 1'b1;
            end
        end
        if (last) begin
            connected_exp_q.push_back(reaches_all(1'b0, n) && reaches_all(1'b1, n));
            for (int r = 0; r < MAX_V; r++) begin
                fwd_rows[r] = '0;
                rev_rows[r] = '0;
            end
        end
    endfunction

    function automatic arc_t mk_arc(int f, int t, bit two, bit last);
        arc_t a;
        a.from_v  = VERTEX_W'(f);
        a.to_v    = VERTEX_W'(t);
        a.two_way = two;
        a.is_last = last;
        return a;
    endfunction

    // Driver: present queued edges, hold them while stalled, insert idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall)
                absorb_arc(i_from_vertex, i_to_vertex, i_two_way, i_last_edge);
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    // begin an idle burst
                    gap_left <= $urandom_range(0, 8);
                    i_valid  <= 1'b0;
                end else if (arc_q.size() != 0) begin
                    i_valid       <= 1'b1;
                    i_from_vertex <= arc_q[0].from_v;
                    i_to_vertex   <= arc_q[0].to_v;
                    i_two_way     <= arc_q[0].two_way;
                    i_last_edge   <= arc_q[0].is_last;
                    arc_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each verdict against the oldest prediction, stall in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (connected_exp_q.size() == 0) begin
                    $display("%0t: unexpected transaction: expected none, actual %0b",
                             $time, o_strongly_connected);
                    mismatches++;
                end else begin
                    want_connected = connected_exp_q.pop_front();
                    if (o_strongly_connected !== want_connected) begin
                        $display("%0t: strongly_connected: expected %0b, actual %0b",
                                 $time, want_connected, o_strongly_connected);
                        mismatches++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_stall    <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 8);
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("strong_connectivity_check_top_tb: errors");
            $finish;
        end
    end

    // Hold the sender until every edge is in and every verdict is out,
    // then let the store sweep finish. Look on the falling edge so that the
    // driver's updates from the rising edge are already visible.
    task automatic settle();
        while (arc_q.size() != 0 || i_valid || connected_exp_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, then access phase; upper data bits are junk
    task automatic write_vertex_count(bit [COUNT_W-1:0] value);
        settle();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VERTEX_COUNT_ADDR;
        pwdata  <= ($urandom() & 32'hFFFF_FF80) | 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        count_reg = value;
    endtask

    task automatic push_arc(arc_t a);
        int unsigned n;
        n = live_count(count_reg);
        arc_q.push_back(a);
        if (a.from_v >= 1 && a.to_v >= 1 && a.from_v <= n && a.to_v <= n)
            random_live++;
    endtask

    function automatic bit [COUNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return COUNT_W'($urandom_range(2, 10));
        if (r < 78) return COUNT_W'($urandom_range(11, 24));
        if (r < 84) return COUNT_W'(1);
        if (r < 88) return COUNT_W'(0);
        if (r < 92) return COUNT_W'(MAX_V);
        return COUNT_W'($urandom_range(MAX_V + 1, 127));
    endfunction

    // One graph: a ring (sometimes cut), a two-way tree or loose edges,
    // plus chords and sometimes one or two out-of-range edges, shuffled, last marker on the end.
    task automatic queue_random_graph();
        arc_t        arcs [$];
        arc_t        tmp_arc;
        int          perm [MAX_V];
        int          n;
        int          kind;
        int          extra;
        int          k;
        int          tmp;
        int          cut;
        int          bad;
        n = live_count(count_reg);
        for (int j = 0; j < n; j++)
            perm[j] = j + 1;
        for (int j = n - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = perm[j];
            perm[j] = perm[k];
            perm[k] = tmp;
        end
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            cut = (kind >= 4) ? $urandom_range(0, n - 1) : -1;
            for (int j = 0; j < n; j++)
                if (j != cut)
                    arcs.push_back(mk_arc(perm[j], perm[(j + 1) % n],
                                          $urandom_range(0, 3) == 0, 1'b0));
        end else if (kind <= 7) begin
            for (int j = 1; j < n; j++)
                arcs.push_back(mk_arc(perm[$urandom_range(0, j - 1)], perm[j], 1'b1, 1'b0));
        end else begin
            extra = $urandom_range(1, 2 * n);
            for (int j = 0; j < extra; j++)
                arcs.push_back(mk_arc($urandom_range(1, n), $urandom_range(1, n),
                                      $urandom_range(0, 1), 1'b0));
        end
        extra = $urandom_range(0, 3);
        for (int j = 0; j < extra; j++)
            arcs.push_back(mk_arc($urandom_range(1, n), $urandom_range(1, n),
                                  $urandom_range(0, 1), 1'b0));
        extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        for (int j = 0; j < extra; j++) begin
            bad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(n + 1, 127);
            if ($urandom_range(0, 1))
                arcs.push_back(mk_arc(bad, $urandom_range(1, n), $urandom_range(0, 1), 1'b0));
            else
                arcs.push_back(mk_arc($urandom_range(1, n), bad, $urandom_range(0, 1), 1'b0));
        end
        if (arcs.size() == 0)
            arcs.push_back(mk_arc($urandom_range(1, n), $urandom_range(1, n), 1'b0, 1'b0));
        for (int j = arcs.size() - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp_arc = arcs[j];
            arcs[j] = arcs[k];
            arcs[k] = tmp_arc;
        end
        arcs[arcs.size() - 1].is_last = 1'b1;
        for (int j = 0; j < arcs.size() - 1; j++)
            push_arc(arcs[j]);
        // Now and then lower the count between loading and the check
        if (n >= 3 && $urandom_range(0, 11) == 0)
            write_vertex_count(COUNT_W'($urandom_range(1, n - 1)));
        push_arc(arcs[arcs.size() - 1]);
    endtask

    initial begin
        wait (i_rst_n);
        // let the clearing pass after reset finish
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Reset count (64): vertex 0 and a vertex above the count are dropped,
        // extremes of the range, self loop, repeated edge carrying the last marker
        push_arc(mk_arc(0, 5, 1'b0, 1'b0));
        push_arc(mk_arc(127, 1, 1'b1, 1'b0));
        push_arc(mk_arc(1, 64, 1'b1, 1'b0));
        push_arc(mk_arc(64, 64, 1'b0, 1'b0));
        push_arc(mk_arc(1, 64, 1'b0, 1'b1));

        // Count 0 acts as one vertex; last marker on a dropped edge still checks
        write_vertex_count(0);
        push_arc(mk_arc(1, 1, 1'b0, 1'b1));
        push_arc(mk_arc(2, 1, 1'b0, 1'b1));

        // Count above the maximum acts as the maximum
        write_vertex_count(127);
        push_arc(mk_arc(127, 127, 1'b1, 1'b1));

        // Three vertices: directed cycle, two-way path, forward-only path
        write_vertex_count(3);
        push_arc(mk_arc(1, 2, 1'b0, 1'b0));
        push_arc(mk_arc(2, 3, 1'b0, 1'b0));
        push_arc(mk_arc(3, 1, 1'b0, 1'b1));
        push_arc(mk_arc(1, 2, 1'b1, 1'b0));
        push_arc(mk_arc(2, 3, 1'b1, 1'b1));
        push_arc(mk_arc(1, 2, 1'b0, 1'b0));
        push_arc(mk_arc(2, 3, 1'b0, 1'b1));

        // Count lowered after loading: vertices above it drop out of the search
        write_vertex_count(4);
        push_arc(mk_arc(1, 2, 1'b1, 1'b0));
        push_arc(mk_arc(2, 4, 1'b1, 1'b0));
        push_arc(mk_arc(2, 3, 1'b1, 1'b0));
        write_vertex_count(2);
        push_arc(mk_arc(4, 4, 1'b0, 1'b1));
        write_vertex_count(4);
        push_arc(mk_arc(1, 3, 1'b1, 1'b0));
        push_arc(mk_arc(3, 2, 1'b1, 1'b0));
        write_vertex_count(2);
        push_arc(mk_arc(0, 0, 1'b0, 1'b1));

        random_live = 0;
        while (random_live < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 0)
                write_vertex_count(pick_count());
            queue_random_graph();
            if (random_live >= CALM_AFTER)
                calm = 1'b1;
        end

        while (arc_q.size() != 0 || i_valid || connected_exp_q.size() != 0)
            @(negedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && connected_exp_q.size() == 0) begin
            $display("strong_connectivity_check_top_tb: clean");
        end else begin
            $display("strong_connectivity_check_top_tb: errors");
        end
        $finish;
    end

endmodule
